/* sv/rcnt_pkg.sv */
// Shared types and constants for the three-channel root counter block.
// Holds the command and result words, the step-unit status and the divider table.
// No dependencies.
package rcnt_pkg;

    // Command word taken on start.
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [15:0] wdata;
        logic [7:0]  cycles;
    } t_cmd;

    // Result word shown with the done strobe.
    typedef struct packed {
        logic [15:0] read_data;
        logic [2:0]  irq_request;
    } t_result;

    // Status of one increment from the shared step unit.
    typedef struct packed {
        logic        go;
        logic [15:0] count;
        logic        reached;
        logic        ovf;
        logic        irq;
    } t_step;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_TARGET = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [1:0] SRC_SYS    = 2'd0;
    localparam logic [1:0] SRC_DOT    = 2'd1;
    localparam logic [1:0] SRC_HBLANK = 2'd2;
    localparam logic [1:0] SRC_SYS8   = 2'd3;

    localparam logic [31:0] WIN_BASE = 32'h1F80_1100;
    localparam logic [31:0] WIN_END  = 32'h1F80_1130;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    localparam int MODE_W          = 13;
    localparam int ACC_W           = 4;
    localparam int MODE_IRQ_TGT    = 3;
    localparam int MODE_IRQ_OVF    = 4;
    localparam int MODE_REPEAT     = 5;
    localparam int MODE_REACHED    = 7;
    localparam int MODE_OVF_SEEN   = 8;
    localparam int MODE_CLEAR      = 12;

    // Prescale divider for a clock source.
    function automatic logic [ACC_W-1:0] divider_of(input logic [1:0] src);
        logic [ACC_W-1:0] d;
        unique case (src)
            SRC_DOT:  d = 4'd11;
            SRC_SYS8: d = 4'd8;
            default:  d = 4'd1;
        endcase
        return d;
    endfunction

endpackage

/* sv/rcnt_step.sv */
// Shared increment unit: one prescale drain step and the two event checks.
// Depends on rcnt_pkg.
module rcnt_step #(
    parameter int SUM_W = 9
) (
    input  logic [SUM_W-1:0]          i_rem,
    input  logic [15:0]               i_count,
    input  logic [15:0]               i_target,
    input  logic [rcnt_pkg::MODE_W-1:0] i_mode,
    input  logic                      i_reached,
    input  logic                      i_ovf,
    output rcnt_pkg::t_step           o_step,
    output logic [SUM_W-1:0]          o_rem
);
    import rcnt_pkg::*;

    logic [ACC_W-1:0] div;
    logic [15:0]      cnt_inc;
    logic             tgt_hit;
    logic             ovf_hit;

    // Divider compare decides whether another increment is due.
    // Increment and check the target match, then the overflow.
    always_comb begin
        div = divider_of(i_mode[1:0]);
        o_step.go = (i_mode[1:0] != SRC_HBLANK) && (i_rem >= SUM_W'(div));
        o_rem = i_rem - SUM_W'(div);

        cnt_inc = i_count + 16'd1;
        tgt_hit = (cnt_inc == i_target) && (!i_reached || i_mode[MODE_REPEAT]);
        ovf_hit = (cnt_inc == CNT_MAX);
        o_step.count   = cnt_inc;
        o_step.reached = i_reached || tgt_hit;
        o_step.ovf     = i_ovf || ovf_hit;
        o_step.irq     = (tgt_hit && i_mode[MODE_IRQ_TGT]) || (ovf_hit && i_mode[MODE_IRQ_OVF]);
    end

endmodule

/* sv/three_channel_root_counter_timers.sv */
// Top level of the three-channel root counter block: bus register window and tick sequencer.
// Depends on rcnt_pkg and rcnt_step.
//
//  Channel   Handshake            Word
//  -------   ------------------   ------------------------------------------
//  command   start in, busy out   i_cmd: func, address, wdata, cycles
//  result    o_done strobe        o_result: read_data, irq_request
//
// A read, a write or an unused func is answered without the sequencer: the result strobes
// in the next cycle and busy stays low, so a new word may follow at once.
// A tick walks the channels through the shared step unit: per channel a load step, the
// increments while the remainder covers the divider and a closing step that stores the
// remainder (hblank: neither); the result then strobes, and the receiver cannot stall it.
// Reset is synchronous and clears all state but r_rem, r_cyc and the result word.
module three_channel_root_counter_timers #(
    parameter int NUM_TIMERS = 3,
    parameter int CYCLE_BITS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rcnt_pkg::t_cmd    i_cmd,
    output logic              o_done,
    output rcnt_pkg::t_result o_result
);
    import rcnt_pkg::*;

    localparam int CB_EFF = (CYCLE_BITS < 8) ? CYCLE_BITS : 8;
    localparam int SUM_W  = ((CB_EFF > ACC_W) ? CB_EFF : ACC_W) + 1;
    localparam int CH_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_TIMERS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;

    // Per-channel state.
    logic [15:0]       r_count   [NUM_TIMERS];
    logic [15:0]       r_target  [NUM_TIMERS];
    logic [MODE_W-1:0] r_mode    [NUM_TIMERS];
    logic [ACC_W-1:0]  r_accum   [NUM_TIMERS];
    logic              r_reached [NUM_TIMERS];
    logic              r_ovf     [NUM_TIMERS];

    // Sequencer and tick registers.
    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CH_W-1:0]   r_ch;
    logic [SUM_W-1:0]  r_rem;
    logic [CB_EFF-1:0] r_cyc;
    logic [2:0]        r_irq;
    logic              r_done;
    t_result           r_result;

    logic              accept;
    logic              in_win;
    logic [1:0]        a_ch;
    logic [1:0]        a_reg;
    logic              ch_ok;
    logic [CH_W-1:0]   a_idx;
    logic [15:0]       rd_data;
    logic [2:0]        ch_bit;
    t_step             step;
    logic [SUM_W-1:0]  step_rem;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_result = r_result;

    // Window decode: channel in offset bits 5..4, register in bits 3..2.
    always_comb begin
        in_win = (i_cmd.address >= WIN_BASE) && (i_cmd.address < WIN_END);
        a_ch   = i_cmd.address[5:4];
        a_reg  = i_cmd.address[3:2];
        ch_ok  = in_win && (32'(a_ch) < NUM_TIMERS);
        a_idx  = ch_ok ? a_ch[CH_W-1:0] : '0;
    end

    // Register read mux.
    always_comb begin
        rd_data = '0;
        if (ch_ok && i_cmd.func == FUNC_READ) begin
            unique case (a_reg)
                REG_COUNT:  rd_data = r_count[a_idx];
                REG_TARGET: rd_data = r_target[a_idx];
                REG_MODE:   rd_data = 16'(r_mode[a_idx]);
                default:    rd_data = '0;
            endcase
        end
    end

    assign ch_bit = 3'(1) << r_ch;

    // The one increment unit, shared by all channels in turn.
    rcnt_step #(
        .SUM_W (SUM_W)
    ) u_step (
        .i_rem     (r_rem),
        .i_count   (r_count[r_ch]),
        .i_target  (r_target[r_ch]),
        .i_mode    (r_mode[r_ch]),
        .i_reached (r_reached[r_ch]),
        .i_ovf     (r_ovf[r_ch]),
        .o_step    (step),
        .o_rem     (step_rem)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_cmd.func == FUNC_TICK) n_state = S_LOAD;
            end
            S_LOAD: n_state = S_STEP;
            S_STEP: begin
                if (!step.go) n_state = (r_ch == LAST_CH) ? S_IDLE : S_LOAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, channel registers and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_ch    <= '0;
            r_irq   <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_count[i]   <= '0;
                r_target[i]  <= '0;
                r_mode[i]    <= '0;
                r_accum[i]   <= '0;
                r_reached[i] <= 1'b0;
                r_ovf[i]     <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ch  <= '0;
                        r_irq <= '0;
                        r_cyc <= i_cmd.cycles[CB_EFF-1:0];
                        if (i_cmd.func != FUNC_TICK) begin
                            r_done <= 1'b1;
                            r_result.read_data   <= rd_data;
                            r_result.irq_request <= '0;
                        end
                        // Register write; mode also loads both flags and may clear.
                        if (ch_ok && i_cmd.func == FUNC_WRITE) begin
                            unique case (a_reg)
                                REG_COUNT:  r_count[a_idx] <= i_cmd.wdata;
                                REG_TARGET: r_target[a_idx] <= i_cmd.wdata;
                                REG_MODE: begin
                                    r_mode[a_idx]    <= i_cmd.wdata[MODE_W-1:0];
                                    r_reached[a_idx] <= i_cmd.wdata[MODE_REACHED];
                                    r_ovf[a_idx]     <= i_cmd.wdata[MODE_OVF_SEEN];
                                    if (i_cmd.wdata[MODE_CLEAR]) begin
                                        r_count[a_idx] <= '0;
                                        r_accum[a_idx] <= '0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_LOAD: begin
                    r_rem <= SUM_W'(r_accum[r_ch]) + SUM_W'(r_cyc);
                end
                S_STEP: begin
                    if (step.go) begin
                        r_rem              <= step_rem;
                        r_count[r_ch]      <= step.count;
                        r_reached[r_ch]    <= step.reached;
                        r_ovf[r_ch]        <= step.ovf;
                        if (step.irq) r_irq <= r_irq | ch_bit;
                    end else begin
                        // Remainder stays as the accumulator; hblank leaves it alone.
                        if (r_mode[r_ch][1:0] != SRC_HBLANK) begin
                            r_accum[r_ch] <= r_rem[ACC_W-1:0];
                        end
                        if (r_ch == LAST_CH) begin
                            r_done <= 1'b1;
                            r_result.read_data   <= '0;
                            r_result.irq_request <= r_irq;
                        end else begin
                            r_ch <= r_ch + CH_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* sv/rcnt_checker.sv */
// Port-level checks for the root counter block, bound to its top level.
// Depends on rcnt_pkg and three_channel_root_counter_timers.
module rcnt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input rcnt_pkg::t_cmd    i_cmd,
    input logic              o_done,
    input rcnt_pkg::t_result o_result
);
    import rcnt_pkg::*;

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("block not idle after reset");

    // An accepted word either starts a tick or answers in the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted word made no progress");

    // A read, a write or an unused func answers at once and never reports interrupts.
    a_access_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func != FUNC_TICK) |=>
        (o_done && !busy && o_result.irq_request == 3'd0))
        else $error("register access result wrong");

    // A write returns zero data.
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_WRITE) |=> (o_result.read_data == 16'd0))
        else $error("write returned data");

    // A tick ends only with its result strobe.
    a_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("tick ended without a result");

endmodule

bind three_channel_root_counter_timers rcnt_checker u_rcnt_checker (.*);
